// ===== rtl/core/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types and constants of the grid raycast column block.
// ----------------------------------------------------------------------------
package grc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int MAP_SIDE  = 64;
   localparam int DIV_W     = 48;
   localparam int SQ_IN_W   = 64;
   localparam int SQ_OUT_W  = 32;
   localparam int CRD_W     = 10;
   localparam int LH_W      = DIV_W + 1;
   localparam int NUM_W     = CRD_W + FRAC_BITS + 1;

   localparam logic [30:0] SAT_MAX = '1;
   localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   localparam logic [2:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_EYE_POS_X     = 3'd2;
   localparam logic [2:0] CSR_EYE_POS_Y     = 3'd3;
   localparam logic [2:0] CSR_VIEW_DIR_X    = 3'd4;
   localparam logic [2:0] CSR_VIEW_DIR_Y    = 3'd5;
   localparam logic [2:0] CSR_CAM_PLANE_X   = 3'd6;
   localparam logic [2:0] CSR_CAM_PLANE_Y   = 3'd7;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CAM_DIV,
      ST_RAY_MUL,
      ST_RAY_SUM,
      ST_SQ_MUL,
      ST_SQ_SUM,
      ST_SQRT,
      ST_DX_DIV,
      ST_DY_DIV,
      ST_SIDE_MUL,
      ST_WALK,
      ST_WALK_RD,
      ST_PERP_START,
      ST_PERP_DIV,
      ST_LH_START,
      ST_LH_DIV,
      ST_ROWS
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quo;
   } div_rsp_type;

   typedef struct packed {
      logic               start;
      logic [SQ_IN_W-1:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic                done;
      logic [SQ_OUT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

// ===== rtl/core/grc_ram.sv =====
// ----------------------------------------------------------------------------
// grc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module grc_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/grc_div.sv =====
// ----------------------------------------------------------------------------
// grc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  grc_pkg::div_req_type div_req,
   output grc_pkg::div_rsp_type div_rsp
);
   import grc_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W:0]   shifted;
   logic             ge;

   always_comb begin
      shifted = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.num;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         rem_in = ge ? (shifted - {1'b0, den_ff}) : shifted;
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

// ===== rtl/core/grc_sqrt.sv =====
// ----------------------------------------------------------------------------
// grc_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module grc_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  grc_pkg::sqrt_req_type sqrt_req,
   output grc_pkg::sqrt_rsp_type sqrt_rsp
);
   import grc_pkg::*;

   localparam int CNT_W = $clog2(SQ_OUT_W);
   localparam int REM_W = SQ_OUT_W + 3;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SQ_IN_W-1:0]  val_ff, val_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [SQ_OUT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]    shifted;
   logic [REM_W-1:0]    sub;
   logic                ge;

   always_comb begin
      shifted = {rem_ff[REM_W-3:0], val_ff[SQ_IN_W-1 -: 2]};
      sub     = {1'b0, root_ff, 2'b01};
      ge      = shifted >= sub;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (sqrt_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = sqrt_req.value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? (shifted - sub) : shifted;
         root_in = {root_ff[SQ_OUT_W-2:0], ge};
         val_in  = {val_ff[SQ_IN_W-3:0], 2'b00};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SQ_OUT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = root_ff;

endmodule

// ===== rtl/core/grid_raycast_column_top.sv =====
// ----------------------------------------------------------------------------
// grid_raycast_column_top
// Tile map in a RAM, cast sequencer with shared divider and square root.
// ----------------------------------------------------------------------------
// After reset the tile RAM is cleared, one entry per cycle, through all
// MAP_SIDE*MAP_SIDE entries (4096 by default); req_ready stays low meanwhile,
// config writes are taken. A tile write gives no word. A cast takes one
// item at a time: each grid step of the walk is one RAM read and its check,
// up to MAX_STEPS steps. Most work outside the walk is the 48-bit divider,
// used up to five times, and the square root with its 32-bit root. The
// result register frees the input side while a word waits.
module grid_raycast_column_top #(
   parameter int MAX_STEPS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [9:0]  req_column,
   input  logic [5:0]  req_tile_x,
   input  logic [5:0]  req_tile_y,
   input  logic        req_tile_wall,
   input  logic [23:0] req_tile_color,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_out_column,
   output logic [9:0]  rsp_row_first,
   output logic [9:0]  rsp_row_last,
   output logic [23:0] rsp_wall_color,
   output logic        rsp_wall_side,
   output logic [5:0]  rsp_hit_x,
   output logic [5:0]  rsp_hit_y,
   output logic        rsp_no_hit,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [21:0] csr_data
);
   import grc_pkg::*;

   localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(MAP_SIDE);
   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int SD_W   = 32 + STEP_W;
   localparam logic signed [CRD_W-1:0] MAP_LIM = CRD_W'(MAP_SIDE);

   // config registers
   logic [10:0]        csr_w_ff, csr_h_ff;
   logic [21:0]        csr_px_ff, csr_py_ff;
   logic signed [17:0] csr_dx_ff, csr_dy_ff, csr_plx_ff, csr_ply_ff;

   state_type state_ff, state_in;
   logic [ADDR_W-1:0]       clr_addr_ff, clr_addr_in;
   logic [9:0]              col_ff, col_in;
   logic signed [31:0]      cam_ff, cam_in;
   logic signed [49:0]      prodx_ff, prodx_in, prody_ff, prody_in;
   logic signed [31:0]      rdx_ff, rdx_in, rdy_ff, rdy_in;
   logic [61:0]             sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [31:0]             len_ff, len_in;
   logic [30:0]             dx_ff, dx_in, dy_ff, dy_in;
   logic [SD_W-1:0]         sidex_ff, sidex_in, sidey_ff, sidey_in;
   logic signed [CRD_W-1:0] mx_ff, mx_in, my_ff, my_in;
   logic                    side_ff, side_in;
   logic [STEP_W-1:0]       n_ff, n_in;
   logic [23:0]             color_ff, color_in;
   logic                    miss_ff, miss_in;
   logic signed [LH_W-1:0]  perp_ff, perp_in, lh_ff, lh_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [9:0]  rsp_col_ff, rsp_col_in, rsp_ds_ff, rsp_ds_in, rsp_de_ff, rsp_de_in;
   logic [23:0] rsp_color_ff, rsp_color_in;
   logic        rsp_side_ff, rsp_side_in, rsp_miss_ff, rsp_miss_in;
   logic [5:0]  rsp_hx_ff, rsp_hx_in, rsp_hy_ff, rsp_hy_in;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [24:0]       wr_data, rd_data;

   logic               accept;
   logic [30:0]        absx, absy;
   logic signed [63:0] sqx_full, sqy_full;
   logic signed [49:0] shx, shy;
   logic signed [34:0] sumx, sumy;
   logic [16:0]        fx, fy;
   logic [47:0]        sdx_full, sdy_full;
   logic               take_x;
   logic signed [CRD_W-1:0] nmx, nmy;
   logic               outside;
   logic signed [CRD_W-1:0] msel;
   logic [21:0]        psel;
   logic signed [31:0] rsel;
   logic [30:0]        rabs;
   logic signed [NUM_W-1:0] num;
   logic [NUM_W-2:0]   num_abs;
   logic               perp_neg;
   logic [LH_W-1:0]    perp_abs;
   logic signed [LH_W-1:0] lh_adj, half;
   logic signed [LH_W:0]   hh_s, half_s, ds, de, hi_s;
   logic [9:0]         hi;
   logic [CRD_W-1:0]   cx, cy;
   logic               out_free;

   function automatic logic [30:0] sat_delta(input logic [DIV_W-1:0] q, input logic zden);
      if (zden || q > DIV_W'(SAT_MAX)) begin
         return SAT_MAX;
      end
      return q[30:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_w_ff   <= 11'd640;
         csr_h_ff   <= 11'd480;
         csr_px_ff  <= 22'd131072;
         csr_py_ff  <= 22'd131072;
         csr_dx_ff  <= -18'sd65536;
         csr_dy_ff  <= 18'sd0;
         csr_plx_ff <= 18'sd0;
         csr_ply_ff <= 18'sd43253;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  csr_w_ff   <= csr_data[10:0];
            CSR_SCREEN_HEIGHT: csr_h_ff   <= csr_data[10:0];
            CSR_EYE_POS_X:     csr_px_ff  <= csr_data;
            CSR_EYE_POS_Y:     csr_py_ff  <= csr_data;
            CSR_VIEW_DIR_X:    csr_dx_ff  <= $signed(csr_data[17:0]);
            CSR_VIEW_DIR_Y:    csr_dy_ff  <= $signed(csr_data[17:0]);
            CSR_CAM_PLANE_X:   csr_plx_ff <= $signed(csr_data[17:0]);
            CSR_CAM_PLANE_Y:   csr_ply_ff <= $signed(csr_data[17:0]);
            default: ;
         endcase
      end
   end

   grc_ram #(.WIDTH(25), .DEPTH(DEPTH)) u_tiles (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   grc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   grc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      // datapath helpers
      absx     = rdx_ff[31] ? 31'(-rdx_ff) : rdx_ff[30:0];
      absy     = rdy_ff[31] ? 31'(-rdy_ff) : rdy_ff[30:0];
      sqx_full = rdx_ff * rdx_ff;
      sqy_full = rdy_ff * rdy_ff;
      shx      = prodx_ff >>> FRAC_BITS;
      shy      = prody_ff >>> FRAC_BITS;
      sumx     = 35'(shx) + 35'(csr_dx_ff);
      sumy     = 35'(shy) + 35'(csr_dy_ff);
      fx       = rdx_ff[31] ? {1'b0, csr_px_ff[15:0]} : (ONE_FX - {1'b0, csr_px_ff[15:0]});
      fy       = rdy_ff[31] ? {1'b0, csr_py_ff[15:0]} : (ONE_FX - {1'b0, csr_py_ff[15:0]});
      sdx_full = fx * dx_ff;
      sdy_full = fy * dy_ff;
      take_x   = sidex_ff < sidey_ff;
      nmx      = mx_ff;
      nmy      = my_ff;
      if (take_x) begin
         nmx = rdx_ff[31] ? (mx_ff - CRD_W'(1)) : (mx_ff + CRD_W'(1));
      end else begin
         nmy = rdy_ff[31] ? (my_ff - CRD_W'(1)) : (my_ff + CRD_W'(1));
      end
      outside = (nmx < 0) || (nmy < 0) || (nmx >= MAP_LIM) || (nmy >= MAP_LIM);
      msel     = side_ff ? my_ff : mx_ff;
      psel     = side_ff ? csr_py_ff : csr_px_ff;
      rsel     = side_ff ? rdy_ff : rdx_ff;
      rabs     = side_ff ? absy : absx;
      num      = NUM_W'($signed({msel, {FRAC_BITS{1'b0}}})) - $signed(NUM_W'(psel));
      if (rsel[31]) begin
         num = num + $signed(NUM_W'(ONE_FX));
      end
      num_abs  = num[NUM_W-1] ? (NUM_W-1)'(-num) : num[NUM_W-2:0];
      perp_neg = num[NUM_W-1] ^ rsel[31];
      perp_abs = perp_ff[LH_W-1] ? LH_W'(-perp_ff) : LH_W'(perp_ff);

      // rows
      lh_adj = lh_ff + $signed({{(LH_W-1){1'b0}}, lh_ff[LH_W-1]});
      half   = lh_adj >>> 1;
      half_s = {half[LH_W-1], half};
      hh_s   = $signed({{(LH_W-9){1'b0}}, csr_h_ff[10:1]});
      ds     = hh_s - half_s;
      de     = hh_s + half_s;
      if (csr_h_ff == 11'd0) begin
         hi = '0;
      end else if (csr_h_ff > 11'd1024) begin
         hi = 10'd1023;
      end else begin
         hi = 10'(csr_h_ff - 11'd1);
      end
      hi_s = $signed({{(LH_W-9){1'b0}}, hi});
      if (mx_ff < 0) begin
         cx = '0;
      end else if (mx_ff >= MAP_LIM) begin
         cx = CRD_W'(MAP_SIDE - 1);
      end else begin
         cx = mx_ff;
      end
      if (my_ff < 0) begin
         cy = '0;
      end else if (my_ff >= MAP_LIM) begin
         cy = CRD_W'(MAP_SIDE - 1);
      end else begin
         cy = my_ff;
      end

      // defaults
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      col_in      = col_ff;
      cam_in      = cam_ff;
      prodx_in    = prodx_ff;
      prody_in    = prody_ff;
      rdx_in      = rdx_ff;
      rdy_in      = rdy_ff;
      sqx_in      = sqx_ff;
      sqy_in      = sqy_ff;
      len_in      = len_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      sidex_in    = sidex_ff;
      sidey_in    = sidey_ff;
      mx_in       = mx_ff;
      my_in       = my_ff;
      side_in     = side_ff;
      n_in        = n_ff;
      color_in    = color_ff;
      miss_in     = miss_ff;
      perp_in     = perp_ff;
      lh_in       = lh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_col_in   = rsp_col_ff;
      rsp_ds_in    = rsp_ds_ff;
      rsp_de_in    = rsp_de_ff;
      rsp_color_in = rsp_color_ff;
      rsp_side_in  = rsp_side_ff;
      rsp_miss_in  = rsp_miss_ff;
      rsp_hx_in    = rsp_hx_ff;
      rsp_hy_in    = rsp_hy_ff;
      div_req      = '0;
      sqrt_req     = '0;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(ADDR_W'(req_tile_y) * ADDR_W'(MAP_SIDE) + ADDR_W'(req_tile_x));
      wr_data      = {req_tile_wall, req_tile_color};
      rd_en        = 1'b0;
      rd_addr      = ADDR_W'(ADDR_W'(nmy[IDX_W-1:0]) * ADDR_W'(MAP_SIDE)
                             + ADDR_W'(nmx[IDX_W-1:0]));

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_WRITE) begin
                  wr_en = (32'(req_tile_x) < MAP_SIDE) && (32'(req_tile_y) < MAP_SIDE);
               end else begin
                  col_in        = req_column;
                  div_req.start = 1'b1;
                  div_req.num   = DIV_W'({req_column, 17'b0});
                  div_req.den   = DIV_W'(csr_w_ff);
                  state_in      = ST_CAM_DIV;
               end
            end
         end
         ST_CAM_DIV: begin
            if (div_rsp.done) begin
               cam_in = ((csr_w_ff == 11'd0) ? $signed({1'b0, SAT_MAX}) :
                         $signed(div_rsp.quo[31:0])) - $signed(32'(ONE_FX));
               state_in = ST_RAY_MUL;
            end
         end
         ST_RAY_MUL: begin
            prodx_in = csr_plx_ff * cam_ff;
            prody_in = csr_ply_ff * cam_ff;
            state_in = ST_RAY_SUM;
         end
         ST_RAY_SUM: begin
            if (sumx > 35'sh7FFFFFFF) begin
               rdx_in = $signed({1'b0, SAT_MAX});
            end else if (sumx < -35'sh7FFFFFFF) begin
               rdx_in = -$signed({1'b0, SAT_MAX});
            end else begin
               rdx_in = sumx[31:0];
            end
            if (sumy > 35'sh7FFFFFFF) begin
               rdy_in = $signed({1'b0, SAT_MAX});
            end else if (sumy < -35'sh7FFFFFFF) begin
               rdy_in = -$signed({1'b0, SAT_MAX});
            end else begin
               rdy_in = sumy[31:0];
            end
            state_in = ST_SQ_MUL;
         end
         ST_SQ_MUL: begin
            sqx_in   = sqx_full[61:0];
            sqy_in   = sqy_full[61:0];
            state_in = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            sqrt_req.start = 1'b1;
            sqrt_req.value = SQ_IN_W'(sqx_ff) + SQ_IN_W'(sqy_ff);
            state_in       = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_rsp.done) begin
               len_in        = sqrt_rsp.root;
               div_req.start = 1'b1;
               div_req.num   = {sqrt_rsp.root, {FRAC_BITS{1'b0}}};
               div_req.den   = DIV_W'(absx);
               state_in      = ST_DX_DIV;
            end
         end
         ST_DX_DIV: begin
            if (div_rsp.done) begin
               dx_in         = sat_delta(div_rsp.quo, absx == 31'd0);
               div_req.start = 1'b1;
               div_req.num   = {len_ff, {FRAC_BITS{1'b0}}};
               div_req.den   = DIV_W'(absy);
               state_in      = ST_DY_DIV;
            end
         end
         ST_DY_DIV: begin
            if (div_rsp.done) begin
               dy_in    = sat_delta(div_rsp.quo, absy == 31'd0);
               state_in = ST_SIDE_MUL;
            end
         end
         ST_SIDE_MUL: begin
            sidex_in = SD_W'(sdx_full[47:FRAC_BITS]);
            sidey_in = SD_W'(sdy_full[47:FRAC_BITS]);
            mx_in    = $signed(CRD_W'(csr_px_ff[21:FRAC_BITS]));
            my_in    = $signed(CRD_W'(csr_py_ff[21:FRAC_BITS]));
            n_in     = '0;
            miss_in  = 1'b0;
            side_in  = 1'b0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (take_x) begin
               sidex_in = sidex_ff + SD_W'(dx_ff);
               side_in  = 1'b0;
            end else begin
               sidey_in = sidey_ff + SD_W'(dy_ff);
               side_in  = 1'b1;
            end
            mx_in = nmx;
            my_in = nmy;
            n_in  = n_ff + 1'b1;
            if (outside) begin
               color_in = '0;
               state_in = ST_PERP_START;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            if (rd_data[24]) begin
               color_in = rd_data[23:0];
               state_in = ST_PERP_START;
            end else if (n_ff == STEP_W'(MAX_STEPS)) begin
               miss_in  = 1'b1;
               state_in = ST_ROWS;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_PERP_START: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'({num_abs, {FRAC_BITS{1'b0}}});
            div_req.den   = DIV_W'(rabs);
            state_in      = ST_PERP_DIV;
         end
         ST_PERP_DIV: begin
            if (div_rsp.done) begin
               if (rabs == 31'd0) begin
                  perp_in = LH_W'($signed({1'b0, SAT_MAX}));
               end else if (perp_neg) begin
                  perp_in = -$signed({1'b0, div_rsp.quo});
               end else begin
                  perp_in = $signed({1'b0, div_rsp.quo});
               end
               state_in = ST_LH_START;
            end
         end
         ST_LH_START: begin
            if (perp_ff == '0) begin
               lh_in    = LH_W'($signed({1'b0, SAT_MAX}));
               state_in = ST_ROWS;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = DIV_W'({csr_h_ff, {FRAC_BITS{1'b0}}});
               div_req.den   = perp_abs[DIV_W-1:0];
               state_in      = ST_LH_DIV;
            end
         end
         ST_LH_DIV: begin
            if (div_rsp.done) begin
               lh_in    = perp_ff[LH_W-1] ? -$signed({1'b0, div_rsp.quo}) :
                                            $signed({1'b0, div_rsp.quo});
               state_in = ST_ROWS;
            end
         end
         ST_ROWS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = col_ff;
               rsp_miss_in  = miss_ff;
               if (miss_ff) begin
                  rsp_ds_in    = '0;
                  rsp_de_in    = '0;
                  rsp_color_in = '0;
                  rsp_side_in  = 1'b0;
                  rsp_hx_in    = '0;
                  rsp_hy_in    = '0;
               end else begin
                  if (ds < 0) begin
                     rsp_ds_in = '0;
                  end else if (ds > hi_s) begin
                     rsp_ds_in = hi;
                  end else begin
                     rsp_ds_in = ds[9:0];
                  end
                  if (de < 0) begin
                     rsp_de_in = '0;
                  end else if (de > hi_s) begin
                     rsp_de_in = hi;
                  end else begin
                     rsp_de_in = de[9:0];
                  end
                  rsp_color_in = color_ff;
                  rsp_side_in  = side_ff;
                  rsp_hx_in    = cx[5:0];
                  rsp_hy_in    = cy[5:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff       <= col_in;
      cam_ff       <= cam_in;
      prodx_ff     <= prodx_in;
      prody_ff     <= prody_in;
      rdx_ff       <= rdx_in;
      rdy_ff       <= rdy_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      len_ff       <= len_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sidex_ff     <= sidex_in;
      sidey_ff     <= sidey_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      side_ff      <= side_in;
      n_ff         <= n_in;
      color_ff     <= color_in;
      miss_ff      <= miss_in;
      perp_ff      <= perp_in;
      lh_ff        <= lh_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_ds_ff    <= rsp_ds_in;
      rsp_de_ff    <= rsp_de_in;
      rsp_color_ff <= rsp_color_in;
      rsp_side_ff  <= rsp_side_in;
      rsp_miss_ff  <= rsp_miss_in;
      rsp_hx_ff    <= rsp_hx_in;
      rsp_hy_ff    <= rsp_hy_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_column = rsp_col_ff;
   assign rsp_row_first  = rsp_ds_ff;
   assign rsp_row_last   = rsp_de_ff;
   assign rsp_wall_color = rsp_color_ff;
   assign rsp_wall_side  = rsp_side_ff;
   assign rsp_hit_x      = rsp_hx_ff;
   assign rsp_hit_y      = rsp_hy_ff;
   assign rsp_no_hit     = rsp_miss_ff;

endmodule

// ===== tb/sv/grc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_checker
// Watches the request, result and register ports of the raycast column block.
// It keeps its own tile map and register copy, and predicts every cast word.
// Each result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module grc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_cmd,
   input  logic [9:0]  req_column,
   input  logic [5:0]  req_tile_x,
   input  logic [5:0]  req_tile_y,
   input  logic        req_tile_wall,
   input  logic [23:0] req_tile_color,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [9:0]  rsp_out_column,
   input  logic [9:0]  rsp_row_first,
   input  logic [9:0]  rsp_row_last,
   input  logic [23:0] rsp_wall_color,
   input  logic        rsp_wall_side,
   input  logic [5:0]  rsp_hit_x,
   input  logic [5:0]  rsp_hit_y,
   input  logic        rsp_no_hit,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [21:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          casts_checked,
   output int          tiles_written
);
   import grc_pkg::*;

   localparam int MAX_STEPS = 128;
   localparam longint ONE  = 64'sd1 <<< FRAC_BITS;
   localparam longint SAT  = 64'sh7FFF_FFFF;

   typedef struct packed {
      logic [9:0]  column;
      logic [9:0]  row_first;
      logic [9:0]  row_last;
      logic [23:0] color;
      logic        side;
      logic [5:0]  hx;
      logic [5:0]  hy;
      logic        missed;
   } slice_word_type;

   logic [21:0] reg_file [8];
   logic [24:0] tile_map [MAP_SIDE*MAP_SIDE];
   slice_word_type slice_q [$];

   function automatic void load_reset_regs();
      reg_file[CSR_SCREEN_WIDTH]  = 22'd640;
      reg_file[CSR_SCREEN_HEIGHT] = 22'd480;
      reg_file[CSR_EYE_POS_X]     = 22'd131072;
      reg_file[CSR_EYE_POS_Y]     = 22'd131072;
      reg_file[CSR_VIEW_DIR_X]    = 22'h30000;
      reg_file[CSR_VIEW_DIR_Y]    = 22'd0;
      reg_file[CSR_CAM_PLANE_X]   = 22'd0;
      reg_file[CSR_CAM_PLANE_Y]   = 22'd43253;
   endfunction

   function automatic longint sx18(logic [21:0] v);
      return longint'($signed(v[17:0]));
   endfunction

   function automatic longint sat31(longint v);
      if (v > SAT) return SAT;
      if (v < -SAT) return -SAT;
      return v;
   endfunction

   function automatic longint unsigned root_of(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint step_span(longint unsigned len, longint d);
      longint unsigned a, q;
      a = (d < 0) ? longint'(-d) : longint'(d);
      if (a == 0) return SAT;
      q = (len << FRAC_BITS) / a;
      return (q > longint'(SAT)) ? SAT : longint'(q);
   endfunction

   function automatic slice_word_type cast_column(logic [9:0] col);
      longint w, h, cam, rdx, rdy, dx, dy, mx, my, stx, sty, num, perp, lh, ds, de, hi;
      longint unsigned len, sdx, sdy, fx, fy, px, py;
      logic [24:0] tile;
      logic [23:0] color;
      bit hit, side;
      slice_word_type r;
      w = longint'(reg_file[CSR_SCREEN_WIDTH][10:0]);
      h = longint'(reg_file[CSR_SCREEN_HEIGHT][10:0]);
      px = reg_file[CSR_EYE_POS_X];
      py = reg_file[CSR_EYE_POS_Y];
      cam = (w == 0) ? SAT : ((longint'(col) * 2) <<< FRAC_BITS) / w;
      cam = cam - ONE;
      rdx = sat31(sx18(reg_file[CSR_VIEW_DIR_X])
                  + ((sx18(reg_file[CSR_CAM_PLANE_X]) * cam) >>> FRAC_BITS));
      rdy = sat31(sx18(reg_file[CSR_VIEW_DIR_Y])
                  + ((sx18(reg_file[CSR_CAM_PLANE_Y]) * cam) >>> FRAC_BITS));
      len = root_of(longint'(rdx * rdx) + longint'(rdy * rdy));
      dx = step_span(len, rdx);
      dy = step_span(len, rdy);
      mx = longint'(px >> FRAC_BITS);
      my = longint'(py >> FRAC_BITS);
      fx = px & (ONE - 1);
      fy = py & (ONE - 1);
      if (rdx < 0) stx = -1;
      else begin
         stx = 1;
         fx = ONE - fx;
      end
      if (rdy < 0) sty = -1;
      else begin
         sty = 1;
         fy = ONE - fy;
      end
      sdx = (fx * dx) >> FRAC_BITS;
      sdy = (fy * dy) >> FRAC_BITS;
      hit = 0;
      side = 0;
      color = '0;
      for (int n = 0; n < MAX_STEPS; n++) begin
         if (sdx < sdy) begin
            sdx += dx;
            mx += stx;
            side = 0;
         end else begin
            sdy += dy;
            my += sty;
            side = 1;
         end
         if (mx < 0 || my < 0 || mx >= MAP_SIDE || my >= MAP_SIDE) begin
            color = '0;
            hit = 1;
            break;
         end
         tile = tile_map[my * MAP_SIDE + mx];
         if (tile[24]) begin
            color = tile[23:0];
            hit = 1;
            break;
         end
      end
      r = '0;
      r.column = col;
      if (!hit) begin
         r.missed = 1'b1;
         return r;
      end
      if (side == 0) begin
         num = mx * ONE - longint'(px) + ((stx < 0) ? ONE : 0);
         perp = (rdx == 0) ? SAT : (num * ONE) / rdx;
      end else begin
         num = my * ONE - longint'(py) + ((sty < 0) ? ONE : 0);
         perp = (rdy == 0) ? SAT : (num * ONE) / rdy;
      end
      lh = (perp == 0) ? SAT : (h * ONE) / perp;
      ds = -(lh / 2) + h / 2;
      de = lh / 2 + h / 2;
      hi = h - 1;
      if (hi > 1023) hi = 1023;
      if (hi < 0) hi = 0;
      if (ds < 0) ds = 0;
      if (ds > hi) ds = hi;
      if (de < 0) de = 0;
      if (de > hi) de = hi;
      r.row_first = ds[9:0];
      r.row_last = de[9:0];
      r.color = color;
      r.side = side;
      r.hx = (mx < 0) ? 6'd0 : (mx >= MAP_SIDE) ? 6'(MAP_SIDE - 1) : mx[5:0];
      r.hy = (my < 0) ? 6'd0 : (my >= MAP_SIDE) ? 6'(MAP_SIDE - 1) : my[5:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch: %s got %0d expected %0d at %0t", field, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      casts_checked = 0;
      tiles_written = 0;
      load_reset_regs();
   end

   always @(posedge clock) begin
      slice_word_type want;
      if (reset) begin
         load_reset_regs();
         foreach (tile_map[i]) tile_map[i] = '0;
         slice_q.delete();
      end else begin
         if (csr_wr_en)
            reg_file[csr_index] = csr_data;
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_WRITE) begin
               tile_map[req_tile_y * MAP_SIDE + req_tile_x] = {req_tile_wall, req_tile_color};
               tiles_written++;
            end else begin
               slice_q.push_back(cast_column(req_column));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (slice_q.size() == 0) begin
               report_mismatch("unexpected word, column", longint'(rsp_out_column), -64'sd1);
            end else begin
               want = slice_q.pop_front();
               casts_checked++;
               if (rsp_out_column != want.column)
                  report_mismatch("out_column", longint'(rsp_out_column),
                                  longint'(want.column));
               if (rsp_row_first != want.row_first)
                  report_mismatch("row_first", longint'(rsp_row_first),
                                  longint'(want.row_first));
               if (rsp_row_last != want.row_last)
                  report_mismatch("row_last", longint'(rsp_row_last),
                                  longint'(want.row_last));
               if (rsp_wall_color != want.color)
                  report_mismatch("wall_color", longint'(rsp_wall_color),
                                  longint'(want.color));
               if (rsp_wall_side != want.side)
                  report_mismatch("wall_side", longint'(rsp_wall_side),
                                  longint'(want.side));
               if (rsp_hit_x != want.hx)
                  report_mismatch("hit_x", longint'(rsp_hit_x), longint'(want.hx));
               if (rsp_hit_y != want.hy)
                  report_mismatch("hit_y", longint'(rsp_hit_y), longint'(want.hy));
               if (rsp_no_hit != want.missed)
                  report_mismatch("no_hit", longint'(rsp_no_hit), longint'(want.missed));
            end
         end
      end
      pending = slice_q.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the grid raycast column block.
// Directed tile writes and casts, then phases of fixed or random register
// settings, sparse random walls, random casts, idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import grc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CMD_WRITE;
   logic [9:0]  req_column = '0;
   logic [5:0]  req_tile_x = '0;
   logic [5:0]  req_tile_y = '0;
   logic        req_tile_wall = 1'b0;
   logic [23:0] req_tile_color = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [9:0]  rsp_out_column;
   logic [9:0]  rsp_row_first;
   logic [9:0]  rsp_row_last;
   logic [23:0] rsp_wall_color;
   logic        rsp_wall_side;
   logic [5:0]  rsp_hit_x;
   logic [5:0]  rsp_hit_y;
   logic        rsp_no_hit;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [21:0] csr_data = '0;

   int fail_count, pending, casts_checked, tiles_written;
   bit calm = 0;
   int rsp_hold = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   grid_raycast_column_top uut (.*);

   grc_checker chk (.*);

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_hold = $urandom_range(1, 11) - 1;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // called at a falling edge; returns at a falling edge after acceptance
   task automatic send_word(logic cmd, logic [9:0] col, logic [5:0] tx, logic [5:0] ty,
                            logic wall, logic [23:0] color);
      req_cmd = cmd;
      req_column = col;
      req_tile_x = tx;
      req_tile_y = ty;
      req_tile_wall = wall;
      req_tile_color = color;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
   endtask

   task automatic cast(logic [9:0] col);
      send_word(CMD_CAST, col, 6'($urandom), 6'($urandom), 1'($urandom), 24'($urandom));
   endtask

   task automatic put_tile(logic [5:0] tx, logic [5:0] ty, logic wall, logic [23:0] color);
      send_word(CMD_WRITE, 10'($urandom), tx, ty, wall, color);
   endtask

   task automatic csr_write(logic [2:0] idx, int value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_data = 22'(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_view(int w, int h, int ex, int ey, int dx, int dy, int plx, int ply);
      csr_write(CSR_SCREEN_WIDTH, w);
      csr_write(CSR_SCREEN_HEIGHT, h);
      csr_write(CSR_EYE_POS_X, ex);
      csr_write(CSR_EYE_POS_Y, ey);
      csr_write(CSR_VIEW_DIR_X, dx);
      csr_write(CSR_VIEW_DIR_Y, dy);
      csr_write(CSR_CAM_PLANE_X, plx);
      csr_write(CSR_CAM_PLANE_Y, ply);
   endtask

   function automatic int rand_q1();
      return int'($urandom_range(0, 262143)) - 131072;
   endfunction

   initial begin
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // default view: ray along -x, center column has a zero y component
      cast(10'd0);
      cast(10'd320);
      cast(10'd639);
      cast(10'd1023);
      put_tile(6'd1, 6'd2, 1'b1, 24'h555555);
      put_tile(6'd3, 6'd2, 1'b0, 24'hFFFFFF);
      put_tile(6'd0, 6'd0, 1'b1, 24'hFFFFFF);
      put_tile(6'd63, 6'd63, 1'b1, 24'h000000);
      cast(10'd320);
      cast(10'd100);
      put_tile(6'd1, 6'd2, 1'b0, 24'hAAAAAA);
      cast(10'd320);
      drain();

      // corner eye looking along the diagonal: longest walk, to the far corner wall
      set_view(1, 1, 0, 0, 65536, 65536, 0, 0);
      cast(10'd0);
      drain();
      set_view(1, 1, 0, 0, -131072, -131072, -131072, -131072);
      cast(10'd0);
      cast(10'd1023);
      drain();
      set_view(1024, 1024, 4194303, 4194303, 131071, 131071, 131071, 131071);
      cast(10'd0);
      cast(10'd512);
      cast(10'd1023);
      drain();
      // zero width and zero height: saturated camera position, rows forced to 0
      set_view(0, 0, 131072, 131072, 0, 0, 0, 0);
      cast(10'd0);
      cast(10'd7);
      drain();

      for (int p = 0; p < 8; p++) begin
         calm = (p == 7);
         case (p)
            0: set_view(1, 1, 0, 0, -131072, -131072, -131072, -131072);
            1: set_view(1024, 1024, 4194303, 4194303, 131071, 131071, 131071, 131071);
            2: set_view(1024, 1, 2097152, 2097152, rand_q1(), rand_q1(), 0, 0);
            default: set_view($urandom_range(1, 1024), $urandom_range(1, 1024),
                               $urandom_range(0, 4194303), $urandom_range(0, 4194303),
                               rand_q1(), rand_q1(), rand_q1(), rand_q1());
         endcase
         for (int i = 0; i < 210; i++) begin
            if ($urandom_range(0, 9) < 4)
               put_tile(6'($urandom), 6'($urandom), ($urandom_range(0, 9) == 0),
                        24'($urandom));
            else
               cast(10'($urandom_range(0, 1023)));
         end
         drain();
      end

      repeat (600) @(negedge clock);
      $display("covered %0d casts checked and %0d tile writes over 13 register settings",
               casts_checked, tiles_written);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("timeout with %0d casts outstanding", pending);
      $display("status: fail");
      $finish;
   end

endmodule
